### rtl/bpe_pkg.sv
// bpe_pkg: shared types, constants and the log-constant table of the breakpoint
// envelope evaluator.
// No dependencies; used by every module under rtl but bpe_checker.
package bpe_pkg;

    localparam int VAL_W = 17;
    localparam int EXP_W = 64;
    localparam int ARG_W = 37;
    localparam int DIV_W = 41;
    localparam int EXP_LAST_STEP = 35;

    localparam logic [VAL_W-1:0] FULL_SCALE = 17'd65536;
    localparam logic signed [VAL_W-1:0] TENSION_MIN_MAG = 17'sd40;
    localparam logic [EXP_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    localparam logic [VAL_W-1:0] DEF_X1 = 17'd13107;
    localparam logic [VAL_W-1:0] DEF_Y1 = 17'd32768;
    localparam logic [VAL_W-1:0] DEF_X2 = 17'd65536;
    localparam logic [VAL_W-1:0] DEF_Y2 = 17'd65536;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef logic [ARG_W-1:0] ln_tab_t [0:31];

    typedef struct packed {
        logic [VAL_W-1:0]        x;
        logic [VAL_W-1:0]        y;
        logic signed [VAL_W-1:0] tension;
    } entry_t;

    typedef struct packed {
        logic                    is_eval;
        logic                    wr_ok;
        logic [3:0]              slot;
        logic [VAL_W-1:0]        x;
        logic [VAL_W-1:0]        y;
        logic signed [VAL_W-1:0] tension;
        logic [VAL_W-1:0]        phase;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAST,
        ST_FIRST,
        ST_SCAN,
        ST_FDIV,
        ST_WMUL,
        ST_XSTART,
        ST_EXP,
        ST_NORM,
        ST_WDIV,
        ST_LMUL,
        ST_LADD,
        ST_DONE
    } back_state_t;

    // ln 2 for index 0, ln(1 + 2^-i) otherwise; Q.32, series summed at 60 bits
    function automatic logic [ARG_W-1:0] ln_const(input int i);
        longint     s;
        longint     t;
        int         n;
        logic [63:0] u;
        s = 0;
        if (i == 0)
        begin
            for (n = 1; n <= 60; n++)
            begin
                s += longint'((64'd1 << (60 - n)) / 64'(n));
            end
        end
        else
        begin
            for (n = 1; n * i <= 60; n++)
            begin
                t = longint'((64'd1 << (60 - n * i)) / 64'(n));
                s += ((n & 1) != 0) ? t : -t;
            end
        end
        u = 64'(s) + (64'd1 << 27);
        return ARG_W'(u >> 28);
    endfunction

    function automatic ln_tab_t build_ln_tab();
        ln_tab_t tab;
        for (int i = 0; i < 32; i++)
        begin
            tab[i] = ln_const(i);
        end
        return tab;
    endfunction

    localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

### rtl/breakpoint_envelope_tension_eval.sv
// Breakpoint envelope evaluator: the time an evaluation takes is set by the
// one-entry-a-cycle table scan, up to two 16-step divides, the 36-step
// exponential pair and normalisation.
// One request is worked on at a time; two more wait in the front queue.
// Reset (rst_n low, asynchronous) restores the three-point default curve and
// points_in_use = 3, and empties the queue and result register.
module breakpoint_envelope_tension_eval #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  logic [0:0]         command,
    input  logic [3:0]         point_index,
    input  logic [16:0]        point_x,
    input  logic [16:0]        point_y,
    input  logic signed [16:0] point_tension,
    input  logic [16:0]        phase,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [16:0]        curve_value,
    output logic [0:0]         is_evaluation,
    input  logic               cfg_write_en,
    input  logic [4:0]         cfg_write_data
);

    localparam int NW = ($clog2(MAX_POINTS + 1) > 5) ? $clog2(MAX_POINTS + 1) : 5;

    logic [4:0]           points_in_use_reg;
    logic [NW-1:0]        n_points;
    bpe_pkg::queue_head_t head;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= 5'd3;
        end
        else if (cfg_write_en)
        begin
            points_in_use_reg <= cfg_write_data;
        end
    end

    assign n_points = (NW'(points_in_use_reg) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                                  : NW'(points_in_use_reg);

    bpe_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .command       (command),
        .point_index   (point_index),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_tension (point_tension),
        .phase         (phase),
        .head          (head),
        .pop           (pop)
    );

    bpe_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .n_points      (n_points),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .curve_value   (curve_value),
        .is_evaluation (is_evaluation)
    );

endmodule

### rtl/bpe_front.sv
// bpe_front: takes requests, classifies them and holds them in a two-entry queue.
// Depends on bpe_pkg.
module bpe_front #(
    parameter int MAX_POINTS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    request_valid,
    output logic                    request_stall,
    input  logic [0:0]              command,
    input  logic [3:0]              point_index,
    input  logic [16:0]             point_x,
    input  logic [16:0]             point_y,
    input  logic signed [16:0]      point_tension,
    input  logic [16:0]             phase,
    output bpe_pkg::queue_head_t    head,
    input  logic                    pop
);

    bpe_pkg::item_t q_mem [2];
    bpe_pkg::item_t item_in;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           do_pop;

    always_comb
    begin
        item_in.is_eval = (command[0] == bpe_pkg::CMD_EVAL);
        // slots past the table are acknowledged but never stored
        item_in.wr_ok   = (32'(point_index) < MAX_POINTS);
        item_in.slot    = point_index;
        item_in.x       = point_x;
        item_in.y       = point_y;
        item_in.tension = point_tension;
        item_in.phase   = phase;
    end

    assign request_stall = (count_reg == 2'd2);
    assign push          = request_valid && !request_stall;
    assign do_pop        = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/bpe_exp.sv
// bpe_exp: iterative shift-and-add exponential, Q.32 argument and result,
// one step a cycle over 36 steps. Depends on bpe_pkg (LN_TAB).
module bpe_exp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [36:0] arg,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  step_reg;
    logic [36:0] r_reg;
    logic [63:0] y_reg;
    logic [36:0] lim;
    logic [63:0] y_new;
    logic [2:0]  j;
    logic [4:0]  sh;
    logic [4:0]  idx;
    logic        take;

    always_comb
    begin
        j     = '0;
        sh    = '0;
        idx   = '0;
        if (step_reg < 6'd5)
        begin
            // integer part: multiples of ln 2 become plain shifts
            j     = 3'(6'd4 - step_reg);
            sh    = 5'(6'd1 << j);
            lim   = bpe_pkg::LN_TAB[0] << j;
            y_new = y_reg << sh;
        end
        else
        begin
            idx   = 5'(step_reg - 6'd4);
            lim   = bpe_pkg::LN_TAB[idx];
            y_new = y_reg + (y_reg >> idx);
        end
        take = (r_reg >= lim);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= arg;
            y_reg <= bpe_pkg::ONE_Q32;
        end
        else if (busy_reg && take)
        begin
            r_reg <= r_reg - lim;
            y_reg <= y_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(bpe_pkg::EXP_LAST_STEP))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = y_reg;

endmodule

### rtl/bpe_div.sv
// bpe_div: restoring divider giving floor(num * 65536 / den), saturated at 65536.
// The restoring loop runs only when num < den; otherwise the quotient saturates. Depends on bpe_pkg.
module bpe_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [40:0] num,
    input  logic [40:0] den,
    output logic        done,
    output logic [16:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic        sat_reg;
    logic [3:0]  cnt_reg;
    logic [40:0] rem_reg;
    logic [40:0] den_reg;
    logic [15:0] q_reg;
    logic [41:0] rem2;
    logic        ge;

    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            sat_reg <= (num >= den);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 41'(rem2 - {1'b0, den_reg}) : rem2[40:0];
            q_reg   <= {q_reg[14:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= (num < den);
                done_reg <= (num >= den);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? bpe_pkg::FULL_SCALE : {1'b0, q_reg};

endmodule

### rtl/bpe_back.sv
// bpe_back: breakpoint table, segment search sequencer, warp and interpolation,
// result register. Depends on bpe_pkg, bpe_exp and bpe_div.
module bpe_back #(
    parameter  int MAX_POINTS = 16,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int NW = ($clog2(MAX_POINTS + 1) > 5) ? $clog2(MAX_POINTS + 1) : 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bpe_pkg::queue_head_t    head,
    output logic                    pop,
    input  logic [NW-1:0]           n_points,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [16:0]             curve_value,
    output logic [0:0]              is_evaluation
);

    localparam int AW = IDX_W + 4;

    bpe_pkg::back_state_t state_reg;
    bpe_pkg::back_state_t state_next;

    bpe_pkg::entry_t mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] valid_reg;
    bpe_pkg::entry_t rd_data_reg;
    bpe_pkg::entry_t prev_reg;
    bpe_pkg::entry_t dflt;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wa;
    logic [AW-1:0]    slot_ext;
    logic [IDX_W-1:0] k_reg;
    logic [NW-1:0]    n_m1;
    logic [IDX_W-1:0] n_last;

    logic [16:0]        phase_reg;
    logic [16:0]        y0_reg;
    logic [16:0]        y1_reg;
    logic signed [16:0] tension_reg;
    logic [16:0]        fw_reg;
    logic [16:0]        m_reg;
    logic [16:0]        w_reg;
    logic [16:0]        res_reg;
    logic               is_eval_reg;
    logic [33:0]        prod_reg;
    logic [63:0]        num_reg;
    logic [63:0]        den_reg;
    logic               out_valid_reg;
    logic [16:0]        curve_reg;
    logic               is_eval_out_reg;

    logic        mem_we;
    logic        div_start;
    logic [40:0] div_num;
    logic [40:0] div_den;
    logic        div_done;
    logic [16:0] div_quot;
    logic        exp_start;
    logic        exp_a_done;
    logic        exp_b_done;
    logic [63:0] exp_a;
    logic [63:0] exp_b;
    logic        out_load;

    logic        slot_free;
    logic        found;
    logic [16:0] seg_a;
    logic [16:0] seg_d;
    logic        k_is_last;
    logic        warp_pos;
    logic        warp_neg;
    logic        norm_shift8;
    logic        norm_shift1;
    logic        norm_direct;
    logic        norm_go;
    logic        up;
    logic [16:0] diff;
    logic [16:0] step_val;

    assign slot_ext = AW'(head.item.slot);
    assign wa       = slot_ext[IDX_W-1:0];
    assign n_m1     = n_points - NW'(1);
    assign n_last   = n_m1[IDX_W-1:0];

    assign slot_free = !out_valid_reg || !result_stall;
    assign found     = (prev_reg.x <= phase_reg) && (phase_reg <= rd_data_reg.x);
    assign seg_a     = phase_reg - prev_reg.x;
    assign seg_d     = rd_data_reg.x - prev_reg.x;
    assign k_is_last = (k_reg == n_last);
    assign warp_pos  = (tension_reg > bpe_pkg::TENSION_MIN_MAG);
    assign warp_neg  = (tension_reg < -bpe_pkg::TENSION_MIN_MAG);

    assign norm_shift8 = (den_reg[63:48] != '0);
    assign norm_shift1 = !norm_shift8 && (den_reg[63:40] != '0);
    assign norm_direct = !norm_shift8 && !norm_shift1 &&
                         ((den_reg == '0) || (num_reg >= den_reg));
    assign norm_go     = !norm_shift8 && !norm_shift1 && !norm_direct;

    assign up       = (y1_reg >= y0_reg);
    assign diff     = up ? (y1_reg - y0_reg) : (y0_reg - y1_reg);
    assign step_val = prod_reg[32:16];

    // entries never written read as the reset curve
    always_comb
    begin
        dflt = '0;
        if (rd_addr == IDX_W'(1))
        begin
            dflt.x = bpe_pkg::DEF_X1;
            dflt.y = bpe_pkg::DEF_Y1;
        end
        else if ((MAX_POINTS > 2) && (rd_addr == IDX_W'(2)))
        begin
            dflt.x = bpe_pkg::DEF_X2;
            dflt.y = bpe_pkg::DEF_Y2;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (!head.item.is_eval || (n_points == '0))
                    begin
                        state_next = bpe_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bpe_pkg::ST_FIRST;
                    end
                end
            end
            // the first point is tested before the last one
            bpe_pkg::ST_FIRST:
            begin
                state_next = (phase_reg <= rd_data_reg.x) ? bpe_pkg::ST_DONE
                                                          : bpe_pkg::ST_LAST;
            end
            bpe_pkg::ST_LAST:
            begin
                state_next = (phase_reg >= rd_data_reg.x) ? bpe_pkg::ST_DONE
                                                          : bpe_pkg::ST_SCAN;
            end
            bpe_pkg::ST_SCAN:
            begin
                if (found)
                begin
                    state_next = (seg_d == '0) ? bpe_pkg::ST_DONE : bpe_pkg::ST_FDIV;
                end
                else if (k_is_last)
                begin
                    state_next = bpe_pkg::ST_DONE;
                end
            end
            bpe_pkg::ST_FDIV:
            begin
                if (div_done)
                begin
                    state_next = (warp_pos || warp_neg) ? bpe_pkg::ST_WMUL
                                                        : bpe_pkg::ST_LMUL;
                end
            end
            bpe_pkg::ST_WMUL:   state_next = bpe_pkg::ST_XSTART;
            bpe_pkg::ST_XSTART: state_next = bpe_pkg::ST_EXP;
            bpe_pkg::ST_EXP:
            begin
                if (exp_a_done && exp_b_done)
                begin
                    state_next = bpe_pkg::ST_NORM;
                end
            end
            bpe_pkg::ST_NORM:
            begin
                if (norm_direct)
                begin
                    state_next = bpe_pkg::ST_LMUL;
                end
                else if (norm_go)
                begin
                    state_next = bpe_pkg::ST_WDIV;
                end
            end
            bpe_pkg::ST_WDIV:
            begin
                if (div_done)
                begin
                    state_next = bpe_pkg::ST_LMUL;
                end
            end
            bpe_pkg::ST_LMUL: state_next = bpe_pkg::ST_LADD;
            bpe_pkg::ST_LADD: state_next = bpe_pkg::ST_DONE;
            bpe_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = bpe_pkg::ST_IDLE;
                end
            end
            default: state_next = bpe_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        rd_addr   = '0;
        div_start = 1'b0;
        div_num   = {24'd0, seg_a};
        div_den   = {24'd0, seg_d};
        exp_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                pop     = head.valid;
                mem_we  = head.valid && !head.item.is_eval && head.item.wr_ok;
                rd_addr = '0;
            end
            bpe_pkg::ST_FIRST: rd_addr = n_last;
            bpe_pkg::ST_LAST:  rd_addr = IDX_W'(1);
            bpe_pkg::ST_SCAN:
            begin
                rd_addr   = k_reg + IDX_W'(1);
                div_start = found && (seg_d != '0);
            end
            bpe_pkg::ST_XSTART: exp_start = 1'b1;
            bpe_pkg::ST_NORM:
            begin
                div_num   = num_reg[40:0];
                div_den   = den_reg[40:0];
                div_start = norm_go;
            end
            bpe_pkg::ST_DONE: out_load = slot_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    bpe_exp u_exp_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .arg    ({prod_reg[32:0], 4'b0000}),
        .done   (exp_a_done),
        .result (exp_a)
    );

    bpe_exp u_exp_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .arg    ({m_reg, 20'd0}),
        .done   (exp_b_done),
        .result (exp_b)
    );

    bpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wa] <= '{x: head.item.x, y: head.item.y, tension: head.item.tension};
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : dflt;

        case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                phase_reg   <= head.item.phase;
                is_eval_reg <= head.item.is_eval;
                res_reg     <= head.item.is_eval ? bpe_pkg::FULL_SCALE : '0;
            end
            bpe_pkg::ST_FIRST:
            begin
                res_reg  <= rd_data_reg.y;
                prev_reg <= rd_data_reg;
                k_reg    <= IDX_W'(1);
            end
            bpe_pkg::ST_LAST:
            begin
                res_reg <= rd_data_reg.y;
            end
            bpe_pkg::ST_SCAN:
            begin
                if (found)
                begin
                    y0_reg      <= prev_reg.y;
                    y1_reg      <= rd_data_reg.y;
                    tension_reg <= prev_reg.tension;
                    res_reg     <= prev_reg.y;
                end
                else
                begin
                    // phase not in this segment: step to the next; if none is left, the result is full scale
                    res_reg  <= bpe_pkg::FULL_SCALE;
                    prev_reg <= rd_data_reg;
                    k_reg    <= k_reg + IDX_W'(1);
                end
            end
            bpe_pkg::ST_FDIV:
            begin
                if (div_done)
                begin
                    w_reg  <= div_quot;
                    fw_reg <= warp_neg ? (bpe_pkg::FULL_SCALE - div_quot) : div_quot;
                    m_reg  <= warp_neg ? 17'(-tension_reg) : 17'(tension_reg);
                end
            end
            bpe_pkg::ST_WMUL:
            begin
                prod_reg <= fw_reg * m_reg;
            end
            bpe_pkg::ST_EXP:
            begin
                num_reg <= exp_a - bpe_pkg::ONE_Q32;
                den_reg <= exp_b - bpe_pkg::ONE_Q32;
            end
            bpe_pkg::ST_NORM:
            begin
                if (norm_shift8)
                begin
                    num_reg <= num_reg >> 8;
                    den_reg <= den_reg >> 8;
                end
                else if (norm_shift1)
                begin
                    num_reg <= num_reg >> 1;
                    den_reg <= den_reg >> 1;
                end
                else if (den_reg == '0)
                begin
                    w_reg <= warp_neg ? (bpe_pkg::FULL_SCALE - fw_reg) : fw_reg;
                end
                else if (num_reg >= den_reg)
                begin
                    w_reg <= warp_neg ? '0 : bpe_pkg::FULL_SCALE;
                end
            end
            bpe_pkg::ST_WDIV:
            begin
                if (div_done)
                begin
                    w_reg <= warp_neg ? (bpe_pkg::FULL_SCALE - div_quot) : div_quot;
                end
            end
            bpe_pkg::ST_LMUL:
            begin
                prod_reg <= diff * w_reg;
            end
            bpe_pkg::ST_LADD:
            begin
                res_reg <= up ? (y0_reg + step_val) : (y0_reg - step_val);
            end
            bpe_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    curve_reg       <= res_reg;
                    is_eval_out_reg <= is_eval_reg;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                valid_reg[wa] <= 1'b1;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign curve_value   = curve_reg;
    assign is_evaluation = is_eval_out_reg;

endmodule

### rtl/bpe_checker.sv
// bpe_checker: port-level checks on the envelope evaluator, bound to the top level.
// Depends only on the top level's ports.
module bpe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        request_valid,
    input logic        request_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [16:0] curve_value,
    input logic [0:0]  is_evaluation
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(curve_value) && $stable(is_evaluation))
        else $error("result changed while stalled");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (is_evaluation == 1'b0) |-> curve_value == 17'd0)
        else $error("write acknowledgement carries a level");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(request_stall) |-> $past(request_valid))
        else $error("queue filled without a request");

endmodule

bind breakpoint_envelope_tension_eval bpe_checker u_bpe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .curve_value   (curve_value),
    .is_evaluation (is_evaluation)
);
